### hw/rtl/csbk_pkg.sv
package csbk_pkg;

  localparam int MSG_BITS = 80;

  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_XOROUT      = 16'hFFFF;
  localparam logic [15:0] CSBK_MASK       = 16'hA5A5;
  localparam logic [15:0] CRC_FINAL       = CRC_XOROUT ^ CSBK_MASK;
  localparam logic [7:0]  PREAMBLE_OPCODE = 8'hBD;
  localparam logic [7:0]  PREAMBLE_FID    = 8'h00;
  localparam logic [7:0]  COMMAND_FID     = 8'h10;
  localparam logic [7:0]  RESERVED_VALUE  = 8'h00;

  localparam logic [1:0] CMD_CHECK   = 2'd0;
  localparam logic [1:0] CMD_MONITOR = 2'd1;
  localparam logic [1:0] CMD_ENABLE  = 2'd2;
  localparam logic [1:0] CMD_DISABLE = 2'd3;

  typedef logic [MSG_BITS-1:0][15:0] crc_cols_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] src;
    logic [23:0] dst;
    logic [15:0] crc_pre;
    logic [15:0] crc_cmd;
  } csbk_entry_t;

  // Column i is the CRC of a message whose only set bit is bit i, where bit
  // MSG_BITS-1 is the first bit shifted in (most significant bit of byte 0).
  function automatic crc_cols_t gen_crc_cols();
    crc_cols_t   cols;
    logic [15:0] acc;
    logic        top;
    logic        mbit;
    for (int i = 0; i < MSG_BITS; i++) begin
      acc = '0;
      for (int j = MSG_BITS - 1; j >= 0; j--) begin
        mbit = (i == j);
        top  = acc[15];
        acc  = {acc[14:0], 1'b0};
        if (top ^ mbit) begin
          acc = acc ^ CRC_POLY;
        end
      end
      cols[i] = acc;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = gen_crc_cols();

  // The CRC with zero init is linear, so it is the xor of the columns of the set bits.
  function automatic logic [15:0] crc_of(input logic [MSG_BITS-1:0] msg);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < MSG_BITS; i++) begin
      if (msg[i]) begin
        r = r ^ CRC_COLS[i];
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] cmd_opcode(input logic [1:0] cmd);
    logic [7:0] r;
    unique case (cmd)
      CMD_CHECK:   r = 8'hA4;
      CMD_MONITOR: r = 8'h9D;
      CMD_ENABLE:  r = 8'hA4;
      CMD_DISABLE: r = 8'hA4;
      default:     r = 8'hA4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmd_argument(input logic [1:0] cmd);
    logic [7:0] r;
    unique case (cmd)
      CMD_CHECK:   r = 8'h00;
      CMD_MONITOR: r = 8'h01;
      CMD_ENABLE:  r = 8'h7E;
      CMD_DISABLE: r = 8'h7F;
      default:     r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/csbk_front.sv
module csbk_front import csbk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  output logic        push,
  output csbk_entry_t push_entry,
  input  logic        q_ready
);

  logic        hold_valid;
  logic [1:0]  hold_cmd;
  logic [23:0] hold_src;
  logic [23:0] hold_dst;

  assign s_tready = !hold_valid || q_ready;
  assign push     = hold_valid && q_ready;

  // Command codes with the top bit set are invalid and are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid && !s_tdata[2];
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold_cmd <= s_tdata[1:0];
      hold_src <= s_tdata[26:3];
      hold_dst <= s_tdata[50:27];
    end
  end

  always_comb begin
    push_entry.cmd     = hold_cmd;
    push_entry.src     = hold_src;
    push_entry.dst     = hold_dst;
    push_entry.crc_pre = crc_of({32'h0, hold_dst, hold_src});
    push_entry.crc_cmd = crc_of({32'h0, hold_src, hold_dst});
  end

endmodule

### hw/rtl/csbk_queue.sv
module csbk_queue import csbk_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  csbk_entry_t push_entry,
  output logic        q_ready,
  input  logic        pop,
  output csbk_entry_t head_entry,
  output logic        head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csbk_entry_t       slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign q_ready    = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### hw/rtl/csbk_back.sv
module csbk_back import csbk_pkg::*; #(
  parameter int PREAMBLE_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,
  input  logic         head_valid,
  input  csbk_entry_t  head_entry,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  output logic         m_tlast
);

  localparam int CNT_W = (PREAMBLE_COUNT > 0) ? $clog2(PREAMBLE_COUNT + 1) : 1;

  logic [7:0]       burst_tag;
  logic [CNT_W-1:0] remaining;
  logic             is_cmd;
  logic             load;

  logic [7:0]  op_next;
  logic [7:0]  fid_next;
  logic [7:0]  ctl_next;
  logic [23:0] first_next;
  logic [23:0] second_next;
  logic [15:0] crc_next;

  logic [7:0]  frame_tag;
  logic [7:0]  opcode_byte;
  logic [7:0]  feature_id;
  logic [7:0]  control_byte;
  logic [23:0] first_address;
  logic [23:0] second_address;
  logic [15:0] frame_crc;
  logic        last_frame;

  assign cfg_ready = 1'b1;
  assign is_cmd    = (remaining == '0);
  assign load      = head_valid && (!m_tvalid || m_tready);
  assign pop       = load && is_cmd;

  always_comb begin
    op_next     = is_cmd ? cmd_opcode(head_entry.cmd) : PREAMBLE_OPCODE;
    fid_next    = is_cmd ? COMMAND_FID : PREAMBLE_FID;
    ctl_next    = is_cmd ? cmd_argument(head_entry.cmd) : 8'(remaining);
    first_next  = is_cmd ? head_entry.src : head_entry.dst;
    second_next = is_cmd ? head_entry.dst : head_entry.src;
    crc_next    = crc_of({op_next, fid_next, RESERVED_VALUE, ctl_next, 48'h0})
                ^ (is_cmd ? head_entry.crc_cmd : head_entry.crc_pre)
                ^ CRC_FINAL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_tag <= '0;
      m_tvalid  <= 1'b0;
      remaining <= CNT_W'(PREAMBLE_COUNT);
    end else begin
      if (cfg_valid) begin
        burst_tag <= cfg_data;
      end
      if (load) begin
        m_tvalid  <= 1'b1;
        remaining <= is_cmd ? CNT_W'(PREAMBLE_COUNT) : remaining - 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_tag      <= burst_tag;
      opcode_byte    <= op_next;
      feature_id     <= fid_next;
      control_byte   <= ctl_next;
      first_address  <= first_next;
      second_address <= second_next;
      frame_crc      <= crc_next;
      last_frame     <= is_cmd;
    end
  end

  assign m_tdata = {frame_crc, second_address, first_address, control_byte,
                    RESERVED_VALUE, feature_id, opcode_byte, frame_tag};
  assign m_tlast = last_frame;

endmodule

### hw/rtl/csbk_command_burst_builder_top.sv
// Channel  Direction  Ports                      Payload
// s        in         s_tvalid s_tready s_tdata  one remote-control request
// m        out        m_tvalid m_tready m_tdata  one CSBK frame, m_tlast on the command frame
// cfg      in         cfg_valid cfg_ready        burst_tag write, cfg_data
//
// A valid request yields PREAMBLE_COUNT + 1 frames, one per cycle from the frame sequencer
// while the m side does not stall; invalid requests are dropped and yield nothing.
// The request queue lets the next requests be taken while a burst is still being sent.
// Reset clears the queue, the output valid and burst_tag, and reloads the frame counter.
// A stalled m side holds the output register; the s side stalls only once the queue is full.
module csbk_command_burst_builder_top import csbk_pkg::*; #(
  parameter int PREAMBLE_COUNT = 16,
  parameter int QUEUE_DEPTH    = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd_code[2:0], source_id[26:3], dest_id[50:27], zero fill [55:51]
  input  logic [55:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // frame_tag[7:0], opcode_byte[15:8], feature_id[23:16], reserved_byte[31:24],
  // control_byte[39:32], first_address[63:40], second_address[87:64], frame_crc[103:88]
  output logic [103:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);

  logic        push;
  logic        q_ready;
  logic        pop;
  logic        head_valid;
  csbk_entry_t push_entry;
  csbk_entry_t head_entry;

  csbk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  csbk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_entry (head_entry),
    .head_valid (head_valid)
  );

  csbk_back #(
    .PREAMBLE_COUNT (PREAMBLE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
